// ----- design/lbp3_pkg.sv -----
// ----------------------------------------------------------------------------
// lbp3_pkg: shared definitions of the 3x3 local binary pattern unit
// Transfer types, register indexes, size constants, the code function and the window shift.
// ----------------------------------------------------------------------------
package lbp3_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int PIXEL_BITS    = 16;
  localparam int CFG_BITS      = 11;
  localparam int HEIGHT_LIMIT  = 1024;
  localparam int FIFO_DEPTH    = 4;
  localparam int CFG_IDX_BITS  = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic signed [PIXEL_BITS-1:0] pix_t;
  typedef pix_t [2:0][2:0] win_t;

  typedef struct packed {
    logic signed [PIXEL_BITS-1:0] pixel_value;
    logic                         drain;
  } lbp_in_t;

  typedef struct packed {
    logic [7:0] pattern_code;
    logic       frame_last;
  } lbp_out_t;

  // Bit weights run clockwise from the upper-left neighbour.
  function automatic logic [7:0] lbp_code(input win_t w);
    logic signed [PIXEL_BITS-1:0] c;
    logic [7:0] k;
    c    = $signed(w[1][1]);
    k[0] = $signed(w[0][0]) >= c;
    k[1] = $signed(w[0][1]) >= c;
    k[2] = $signed(w[0][2]) >= c;
    k[3] = $signed(w[1][2]) >= c;
    k[4] = $signed(w[2][2]) >= c;
    k[5] = $signed(w[2][1]) >= c;
    k[6] = $signed(w[2][0]) >= c;
    k[7] = $signed(w[1][0]) >= c;
    return k;
  endfunction

  function automatic win_t win_shift(input win_t w, input pix_t top, input pix_t mid,
                                     input pix_t bot);
    win_t n;
    for (int i = 0; i < 3; i++) begin
      n[i][0] = w[i][1];
      n[i][1] = w[i][2];
    end
    n[0][2] = top;
    n[1][2] = mid;
    n[2][2] = bot;
    return n;
  endfunction

endpackage

// ----- design/local_binary_pattern_3x3_unit.sv -----
// ----------------------------------------------------------------------------
// local_binary_pattern_3x3_unit: streaming 3x3 local binary pattern coder
// Two row memories and a 3x3 window give an 8-bit neighbour code per pixel.
// ----------------------------------------------------------------------------
// Pixels enter on the input channel in raster order, one transfer each. Each
// code leaves on the output channel, in raster order and one row late: the
// pixel at row r, column c completes the code of row r-1, column c-1, and the
// last pixel of a row also completes the code of the row's last column.
// After the final row the source sends as many drain transfers as the row is
// wide; they act as a zero row below the frame and flush the last row, whose
// final code carries frame_last.
// A transfer is taken every cycle that the input is not stalled; a code passes
// through the window stage and the output queue before it is offered on the
// output. The row memories are read at the transfer and written back in the
// cycle after, with the value forwarded when the next transfer reads the same
// column. The last column yields two codes, so a four-entry output queue
// absorbs them and the input stalls when it cannot hold two more codes.
// When the receiver stalls, codes collect in the queue and the input stalls.
// Reset empties the queue and the pipeline, clears the counters and sets both
// image registers to 128; the row memories hold nothing until written.
// The user must write the image registers only while the unit is idle; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module local_binary_pattern_3x3_unit
  import lbp3_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  lbp_in_t                 in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output lbp_out_t                out_data_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int NW = PW + 2;

  logic [CFG_BITS-1:0] width_q, height_q;
  logic [CW-1:0]       col_cnt_q, col_cnt_d, drain_cnt_q, drain_cnt_d;
  logic [CFG_BITS-1:0] row_cnt_q, row_cnt_d;

  logic [CW-1:0]       wm1;
  logic [CFG_BITS-1:0] height_eff;
  logic                complete, accept, work, last, r1, r2;
  logic [CW-1:0]       cnt_sel, col_sel;

  logic                s1_valid_q, s1_first_q, s1_out1_q, s1_out2_q;
  logic                s1_top_ok_q, s1_mid_ok_q, s1_store_q, s1_fend_q;
  pix_t                s1_pix_q;
  logic [CW-1:0]       s1_idx_q;
  pix_t                upper_rd_q, middle_rd_q, fwd_up_q, fwd_mid_q;
  logic                fwd_q, fwd_d;

  pix_t                upper_mem [MAX_WIDTH];
  pix_t                middle_mem [MAX_WIDTH];

  pix_t                top_use, mid_use;
  win_t                win_q, win_base, win_new, win_tail;
  lbp_out_t            res1, res2, first_res;
  logic [1:0]          n_res;

  lbp_out_t            fifo_q [FIFO_DEPTH];
  logic [PW-1:0]       rd_ptr_q, wr_ptr_q;
  logic [NW-1:0]       fifo_cnt_q;
  logic                pop;
  logic [NW-1:0]       room_need;

  // Configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_BITS'(128);
      height_q <= CFG_BITS'(128);
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_IMAGE_WIDTH) width_q <= cfg_data_i;
      if (cfg_index_i == REG_IMAGE_HEIGHT) height_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (width_q == '0) begin
      wm1 = '0;
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(width_q - CFG_BITS'(1));
    end
    if (height_q == '0) begin
      height_eff = CFG_BITS'(1);
    end else if (height_q > CFG_BITS'(HEIGHT_LIMIT)) begin
      height_eff = CFG_BITS'(HEIGHT_LIMIT);
    end else begin
      height_eff = height_q;
    end
  end

  // Input stage: position counters and memory read.
  assign pop        = out_valid_o && !out_stall_i;
  assign room_need  = fifo_cnt_q - NW'(pop) + NW'(n_res) + NW'(2);
  assign in_stall_o = room_need > NW'(FIFO_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    complete = row_cnt_q >= height_eff;
    work     = complete ? in_data_i.drain : !in_data_i.drain;
    cnt_sel  = complete ? drain_cnt_q : col_cnt_q;
    last     = cnt_sel >= wm1;
    col_sel  = last ? wm1 : cnt_sel;
    r1       = complete || (row_cnt_q != '0);
    r2       = complete ? (height_eff >= CFG_BITS'(2)) : (row_cnt_q >= CFG_BITS'(2));
    col_cnt_d   = col_cnt_q;
    drain_cnt_d = drain_cnt_q;
    row_cnt_d   = row_cnt_q;
    if (accept && work) begin
      if (complete) begin
        if (last) begin
          drain_cnt_d = '0;
          row_cnt_d   = '0;
          col_cnt_d   = '0;
        end else begin
          drain_cnt_d = drain_cnt_q + CW'(1);
        end
      end else begin
        if (last) begin
          col_cnt_d = '0;
          row_cnt_d = row_cnt_q + CFG_BITS'(1);
        end else begin
          col_cnt_d = col_cnt_q + CW'(1);
        end
      end
    end
    fwd_d = accept && work && s1_valid_q && s1_store_q && (s1_idx_q == col_sel);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q   <= '0;
      drain_cnt_q <= '0;
      row_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      col_cnt_q   <= col_cnt_d;
      drain_cnt_q <= drain_cnt_d;
      row_cnt_q   <= row_cnt_d;
      s1_valid_q  <= accept && work;
      fwd_q       <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && work) begin
      s1_first_q  <= col_sel == '0;
      s1_out1_q   <= r1 && (col_sel != '0);
      s1_out2_q   <= r1 && last;
      s1_top_ok_q <= r2;
      s1_mid_ok_q <= r1;
      s1_store_q  <= !complete;
      s1_fend_q   <= complete;
      s1_pix_q    <= complete ? pix_t'(0) : in_data_i.pixel_value;
      s1_idx_q    <= col_sel;
      upper_rd_q  <= upper_mem[col_sel];
      middle_rd_q <= middle_mem[col_sel];
      fwd_up_q    <= mid_use;
      fwd_mid_q   <= s1_pix_q;
    end
  end

  // Window stage: window update, code computation and read-modify-write of the row memories.
  always_comb begin
    top_use  = !s1_top_ok_q ? pix_t'(0) : (fwd_q ? fwd_up_q : upper_rd_q);
    mid_use  = !s1_mid_ok_q ? pix_t'(0) : (fwd_q ? fwd_mid_q : middle_rd_q);
    win_base = s1_first_q ? win_t'(0) : win_q;
    win_new  = win_shift(win_base, top_use, mid_use, s1_pix_q);
    win_tail = win_shift(win_new, pix_t'(0), pix_t'(0), pix_t'(0));
    res1.pattern_code = lbp_code(win_new);
    res1.frame_last   = 1'b0;
    res2.pattern_code = lbp_code(win_tail);
    res2.frame_last   = s1_fend_q;
    n_res     = s1_valid_q ? (2'(s1_out1_q) + 2'(s1_out2_q)) : 2'd0;
    first_res = s1_out1_q ? res1 : res2;
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_store_q) begin
      upper_mem[s1_idx_q]  <= mid_use;
      middle_mem[s1_idx_q] <= s1_pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_valid_q) begin
      win_q <= win_new;
    end
  end

  // Output queue.
  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) fifo_q[wr_ptr_q] <= first_res;
    if (n_res == 2'd2) fifo_q[wr_ptr_q + PW'(1)] <= res2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      rd_ptr_q   <= rd_ptr_q + PW'(pop);
      wr_ptr_q   <= wr_ptr_q + PW'(n_res);
      fifo_cnt_q <= fifo_cnt_q - NW'(pop) + NW'(n_res);
    end
  end

  assign out_valid_o = fifo_cnt_q != '0;
  assign out_data_o  = fifo_q[rd_ptr_q];

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= NW'(FIFO_DEPTH))
    else $error("output queue overflow");

  a_fwd_has_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q)
    else $error("forwarding without an item in the window stage");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col_cnt_q) < 32'(MAX_WIDTH)) && (32'(drain_cnt_q) < 32'(MAX_WIDTH)))
    else $error("column counter beyond the row memory");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_cnt_q == NW'(FIFO_DEPTH)) && !pop |-> n_res == 2'd0)
    else $error("code written into a full output queue");

endmodule
